### sv/cosl_pkg.sv
// ----------------------------------------------------------------------------
// cosl_pkg
// Shared types and constants of the cost sorted open list.
// ----------------------------------------------------------------------------
package cosl_pkg;

    localparam int MAX_ENTRIES_DEF = 64;
    localparam int ID_BITS_DEF     = 16;

    localparam int ID_FIELD_W    = 16;
    localparam int COST_W        = 24;
    localparam int COUNT_FIELD_W = 7;
    localparam int STATUS_W      = 2;

    localparam int S_TDATA_W = 40;   // node_id, cost
    localparam int M_TDATA_W = 48;   // entry_count, head_valid, head_id, head_cost

    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 2'd0,
        ST_EMPTY     = 2'd1,
        ST_NOT_FOUND = 2'd2,
        ST_FULL      = 2'd3
    } t_status;

    typedef enum logic {
        REQ_INSERT = 1'b0,
        REQ_REMOVE = 1'b1
    } t_req;

    typedef struct packed {
        logic ins_en;   // write an insert this cycle
        logic rem_en;   // close the gap of a removed entry this cycle
    } t_cell_ctrl;

endpackage

### sv/cosl_prefix_or.sv
// ----------------------------------------------------------------------------
// cosl_prefix_or
// Log-depth inclusive prefix OR over the per-cell id match flags.
// ----------------------------------------------------------------------------
module cosl_prefix_or
    import cosl_pkg::*;
#(
    parameter int N = MAX_ENTRIES_DEF
) (
    input  logic [N-1:0] i_bits,
    output logic [N-1:0] o_prefix
);

    localparam int LVL = (N > 1) ? $clog2(N) : 1;

    logic [LVL:0][N-1:0] w_lvl;

    assign w_lvl[0] = i_bits;

    for (genvar l = 0; l < LVL; l++) begin : g_lvl
        for (genvar i = 0; i < N; i++) begin : g_bit
            if (i >= (1 << l)) begin : g_or
                assign w_lvl[l+1][i] = w_lvl[l][i] | w_lvl[l][i - (1 << l)];
            end else begin : g_pass
                assign w_lvl[l+1][i] = w_lvl[l][i];
            end
        end
    end

    assign o_prefix = w_lvl[LVL];

endmodule

### sv/cosl_cell.sv
// ----------------------------------------------------------------------------
// cosl_cell
// One list slot: holds an entry, compares it with the request and loads
// its own, its left or its right neighbor's entry, or the new entry.
// ----------------------------------------------------------------------------
module cosl_cell
    import cosl_pkg::*;
#(
    parameter int ID_BITS = ID_BITS_DEF
) (
    input  logic               i_clk,
    input  t_cell_ctrl         i_ctrl,
    input  logic               i_occ,        // slot lies below the count
    input  logic [ID_BITS-1:0] i_new_id,
    input  logic [COST_W-1:0]  i_new_cost,
    input  logic               i_left_lt,    // left slot cost below new cost
    input  logic               i_take_right, // match at or before this slot
    input  logic [ID_BITS-1:0] i_left_id,
    input  logic [COST_W-1:0]  i_left_cost,
    input  logic [ID_BITS-1:0] i_right_id,
    input  logic [COST_W-1:0]  i_right_cost,
    output logic [ID_BITS-1:0] o_id,
    output logic [COST_W-1:0]  o_cost,
    output logic               o_lt,
    output logic               o_match
);

    logic [ID_BITS-1:0] r_id, n_id;
    logic [COST_W-1:0]  r_cost, n_cost;

    assign o_lt    = i_occ && (i_new_cost > r_cost);
    assign o_match = i_occ && (i_new_id == r_id);

    always_comb begin
        n_id   = r_id;
        n_cost = r_cost;
        priority if (i_ctrl.ins_en) begin
            priority if (o_lt) begin
                n_id   = r_id;
                n_cost = r_cost;
            end else if (i_left_lt) begin
                n_id   = i_new_id;
                n_cost = i_new_cost;
            end else begin
                n_id   = i_left_id;
                n_cost = i_left_cost;
            end
        end else if (i_ctrl.rem_en && i_take_right) begin
            n_id   = i_right_id;
            n_cost = i_right_cost;
        end
    end

    always_ff @(posedge i_clk) begin
        r_id   <= n_id;
        r_cost <= n_cost;
    end

    assign o_id   = r_id;
    assign o_cost = r_cost;

endmodule

### sv/cost_sorted_open_list.sv
// ----------------------------------------------------------------------------
// cost_sorted_open_list
// The result is registered and valid the cycle after a request is accepted.
// Throughput: one transaction per cycle while results are taken; all cells
// compare and shift together, remove search: log2(MAX_ENTRIES)-level prefix OR.
// Reset clears the entry count and the result valid; slot contents stay
// undefined and are never read before they are written.
// ----------------------------------------------------------------------------
module cost_sorted_open_list
    import cosl_pkg::*;
#(
    parameter int MAX_ENTRIES = MAX_ENTRIES_DEF,
    parameter int ID_BITS     = ID_BITS_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_s_tvalid,
    output logic                 o_s_tready,
    input  logic [S_TDATA_W-1:0] i_s_tdata,   // node_id[15:0], cost[39:16]
    input  logic                 i_s_tuser,   // req_type
    output logic                 o_m_tvalid,
    input  logic                 i_m_tready,
    output logic [M_TDATA_W-1:0] o_m_tdata,   // entry_count[6:0], head_valid[7],
                                              // head_id[23:8], head_cost[47:24]
    output logic [STATUS_W-1:0]  o_m_tuser    // status
);

    localparam int N     = MAX_ENTRIES;
    localparam int CNT_W = $clog2(MAX_ENTRIES + 1);

    logic [CNT_W-1:0] r_count, n_count;
    t_status          r_status, n_status;
    logic             r_out_valid;

    logic               w_acc;
    t_req               w_req;
    logic [ID_BITS-1:0] w_id;
    logic [COST_W-1:0]  w_cost;
    logic               w_full, w_empty, w_found;
    t_cell_ctrl         w_ctrl;

    logic [N-1:0][ID_BITS-1:0] c_id;
    logic [N-1:0][COST_W-1:0]  c_cost;
    logic [N-1:0]              c_lt, c_match, c_prefix;

    assign o_s_tready = !r_out_valid || i_m_tready;
    assign w_acc      = i_s_tvalid && o_s_tready;
    assign w_req      = t_req'(i_s_tuser);
    assign w_id       = ID_BITS'(i_s_tdata[ID_FIELD_W-1:0]);
    assign w_cost     = i_s_tdata[ID_FIELD_W +: COST_W];

    assign w_full  = (r_count == CNT_W'(MAX_ENTRIES));
    assign w_empty = (r_count == '0);
    assign w_found = c_prefix[N-1];

    cosl_prefix_or #(.N(N)) u_prefix (
        .i_bits   (c_match),
        .o_prefix (c_prefix)
    );

    for (genvar i = 0; i < N; i++) begin : g_cell
        logic               w_left_lt;
        logic [ID_BITS-1:0] w_left_id, w_right_id;
        logic [COST_W-1:0]  w_left_cost, w_right_cost;

        if (i == 0) begin : g_first
            assign w_left_lt   = 1'b1;
            assign w_left_id   = w_id;
            assign w_left_cost = w_cost;
        end else begin : g_mid
            assign w_left_lt   = c_lt[i-1];
            assign w_left_id   = c_id[i-1];
            assign w_left_cost = c_cost[i-1];
        end

        if (i == N - 1) begin : g_last
            assign w_right_id   = c_id[i];
            assign w_right_cost = c_cost[i];
        end else begin : g_inner
            assign w_right_id   = c_id[i+1];
            assign w_right_cost = c_cost[i+1];
        end

        cosl_cell #(.ID_BITS(ID_BITS)) u_cell (
            .i_clk        (i_clk),
            .i_ctrl       (w_ctrl),
            .i_occ        (CNT_W'(i) < r_count),
            .i_new_id     (w_id),
            .i_new_cost   (w_cost),
            .i_left_lt    (w_left_lt),
            .i_take_right (c_prefix[i]),
            .i_left_id    (w_left_id),
            .i_left_cost  (w_left_cost),
            .i_right_id   (w_right_id),
            .i_right_cost (w_right_cost),
            .o_id         (c_id[i]),
            .o_cost       (c_cost[i]),
            .o_lt         (c_lt[i]),
            .o_match      (c_match[i])
        );
    end

    always_comb begin
        w_ctrl   = '0;
        n_count  = r_count;
        n_status = ST_OK;
        unique case (w_req)
            REQ_INSERT: begin
                if (w_full) begin
                    n_status = ST_FULL;
                end else begin
                    w_ctrl.ins_en = w_acc;
                    n_count       = r_count + CNT_W'(1);
                end
            end
            REQ_REMOVE: begin
                priority if (w_empty) begin
                    n_status = ST_EMPTY;
                end else if (!w_found) begin
                    n_status = ST_NOT_FOUND;
                end else begin
                    w_ctrl.rem_en = w_acc;
                    n_count       = r_count - CNT_W'(1);
                end
            end
            default: begin
                n_status = ST_OK;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
            r_status    <= ST_OK;
        end else begin
            if (w_acc) begin
                r_count     <= n_count;
                r_status    <= n_status;
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    logic w_head_valid;
    assign w_head_valid = !w_empty;

    assign o_m_tvalid = r_out_valid;
    assign o_m_tuser  = r_status;
    assign o_m_tdata  = {
        (w_head_valid ? c_cost[0] : COST_W'(0)),
        (w_head_valid ? ID_FIELD_W'(c_id[0]) : ID_FIELD_W'(0)),
        w_head_valid,
        COUNT_FIELD_W'(r_count)
    };

    // ------------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------------
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(MAX_ENTRIES))
        else $error("entry count above capacity");

    a_full_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_status == ST_FULL) |-> w_full)
        else $error("full status while list not full");

    a_reject_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_acc && w_ctrl == '0) |=> $stable(r_count))
        else $error("count changed on rejected transaction");

    a_valid_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(w_acc))
        else $error("result without request transaction");

endmodule

### sim/tb_open_list_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_open_list_checker
// Watches the request and result streams of the cost sorted open list. Every
// accepted request updates a local copy of the sorted list and queues the
// result it should produce. Every accepted result is compared field by field
// with the oldest queued one. Mismatches are counted for the testbench top.
// ----------------------------------------------------------------------------
module tb_open_list_checker
    import cosl_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_s_tvalid,
    input  logic                 i_s_tready,
    input  logic [S_TDATA_W-1:0] i_s_tdata,   // node_id[15:0], cost[39:16]
    input  logic                 i_s_tuser,   // req_type
    input  logic                 i_m_tvalid,
    input  logic                 i_m_tready,
    input  logic [M_TDATA_W-1:0] i_m_tdata,   // entry_count[6:0], head_valid[7],
                                              // head_id[23:8], head_cost[47:24]
    input  logic [STATUS_W-1:0]  i_m_tuser,   // status
    output int                   o_fail_count,
    output int                   o_pending
);

    typedef struct packed {
        t_status                  status;
        logic [COUNT_FIELD_W-1:0] entry_count;
        logic                     head_valid;
        logic [ID_FIELD_W-1:0]    head_id;
        logic [COST_W-1:0]        head_cost;
    } t_list_result;

    logic [ID_FIELD_W-1:0] slot_id   [MAX_ENTRIES_DEF];
    logic [COST_W-1:0]     slot_cost [MAX_ENTRIES_DEF];
    int                    held        = 0;
    int                    mismatches  = 0;
    int                    pending_cnt = 0;
    t_list_result          expected_results[$];
    t_list_result          want;
    t_list_result          got;

    assign o_fail_count = mismatches;
    assign o_pending    = pending_cnt;

    function automatic t_list_result update_open_list(input t_req req,
                                                      input logic [ID_FIELD_W-1:0] id,
                                                      input logic [COST_W-1:0] cost);
        t_list_result res;
        int           pos;
        pos        = 0;
        res.status = ST_OK;
        if (req == REQ_INSERT) begin
            if (held >= MAX_ENTRIES_DEF) begin
                res.status = ST_FULL;
            end else begin
                // new entry goes ahead of entries with equal cost
                while (pos < held && cost > slot_cost[pos])
                    pos++;
                for (int k = held; k > pos; k--) begin
                    slot_id[k]   = slot_id[k-1];
                    slot_cost[k] = slot_cost[k-1];
                end
                slot_id[pos]   = id;
                slot_cost[pos] = cost;
                held++;
            end
        end else if (held == 0) begin
            res.status = ST_EMPTY;
        end else begin
            while (pos < held && slot_id[pos] != id)
                pos++;
            if (pos >= held) begin
                res.status = ST_NOT_FOUND;
            end else begin
                for (int k = pos; k + 1 < held; k++) begin
                    slot_id[k]   = slot_id[k+1];
                    slot_cost[k] = slot_cost[k+1];
                end
                held--;
            end
        end
        res.entry_count = COUNT_FIELD_W'(held);
        res.head_valid  = (held > 0);
        res.head_id     = (held > 0) ? slot_id[0] : '0;
        res.head_cost   = (held > 0) ? slot_cost[0] : '0;
        return res;
    endfunction

    function automatic void check_field(input string name, input logic [31:0] want_v,
                                        input logic [31:0] got_v);
        if (want_v !== got_v) begin
            $display("%0t ns: %s mismatch, expected 0x%0h actual 0x%0h",
                     $time, name, want_v, got_v);
            mismatches++;
        end
    endfunction

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_s_tvalid && i_s_tready)
                expected_results.push_back(update_open_list(t_req'(i_s_tuser),
                                                            i_s_tdata[15:0],
                                                            i_s_tdata[39:16]));
            if (i_m_tvalid && i_m_tready) begin
                got.status      = t_status'(i_m_tuser);
                got.entry_count = i_m_tdata[6:0];
                got.head_valid  = i_m_tdata[7];
                got.head_id     = i_m_tdata[23:8];
                got.head_cost   = i_m_tdata[47:24];
                if (expected_results.size() == 0) begin
                    $display("%0t ns: result transaction with none expected, actual 0x%0h",
                             $time, got);
                    mismatches++;
                end else begin
                    want = expected_results.pop_front();
                    check_field("status", 32'(want.status), 32'(got.status));
                    check_field("entry_count", 32'(want.entry_count), 32'(got.entry_count));
                    check_field("head_valid", 32'(want.head_valid), 32'(got.head_valid));
                    check_field("head_id", 32'(want.head_id), 32'(got.head_id));
                    check_field("head_cost", 32'(want.head_cost), 32'(got.head_cost));
                end
            end
        end
        pending_cnt = expected_results.size();
    end

endmodule

### sim/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Drives insert and remove requests into the cost sorted open list: a short
// directed sequence over empty, not found, tie and duplicate cases, then
// random fill and drain bursts that reach both the full and the empty list,
// under three idling patterns on the request and result streams.
// ----------------------------------------------------------------------------
module tb_top;
    import cosl_pkg::*;

    logic                 clk;
    logic                 rst_n;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata;    // node_id[15:0], cost[39:16]
    logic                 s_tuser;    // req_type
    logic                 m_tvalid;
    logic                 m_tready;
    logic [M_TDATA_W-1:0] m_tdata;    // entry_count[6:0], head_valid[7],
                                      // head_id[23:8], head_cost[47:24]
    logic [STATUS_W-1:0]  m_tuser;    // status
    int                   fail_count;
    int                   pending;
    int                   send_idle_pct = 0;
    int                   recv_idle_pct = 0;
    logic [15:0]          wide_ids[$];

    cost_sorted_open_list dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_s_tvalid (s_tvalid),
        .o_s_tready (s_tready),
        .i_s_tdata  (s_tdata),
        .i_s_tuser  (s_tuser),
        .o_m_tvalid (m_tvalid),
        .i_m_tready (m_tready),
        .o_m_tdata  (m_tdata),
        .o_m_tuser  (m_tuser)
    );

    tb_open_list_checker checker_i (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_s_tvalid   (s_tvalid),
        .i_s_tready   (s_tready),
        .i_s_tdata    (s_tdata),
        .i_s_tuser    (s_tuser),
        .i_m_tvalid   (m_tvalid),
        .i_m_tready   (m_tready),
        .i_m_tdata    (m_tdata),
        .i_m_tuser    (m_tuser),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    initial begin
        #5_000_000;
        $display("status: fail");
        $finish;
    end

    // result side back-pressure
    initial begin
        m_tready = 1'b0;
        forever begin
            @(negedge clk);
            m_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // one request transaction; called and returns at a falling edge
    task automatic send_req(input t_req req, input logic [15:0] id, input logic [23:0] cost);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= req;
        s_tdata  <= {cost, id};
        forever begin
            @(posedge clk);
            if (s_tready)
                break;
        end
        @(negedge clk);
    endtask

    task automatic run_burst(input int n_items, input int insert_pct);
        logic [15:0] id;
        logic [23:0] cost;
        int          roll;
        for (int k = 0; k < n_items; k++) begin
            roll = $urandom_range(99);
            if (roll < 40)
                cost = 24'($urandom_range(7));
            else if (roll < 50)
                cost = '0;
            else if (roll < 60)
                cost = '1;
            else
                cost = 24'($urandom);
            if ($urandom_range(99) < insert_pct) begin
                if ($urandom_range(99) < 25) begin
                    id = 16'($urandom);
                    if (wide_ids.size() > 64)
                        void'(wide_ids.pop_front());
                    wide_ids.push_back(id);
                end else begin
                    id = 16'($urandom_range(15));
                end
                send_req(REQ_INSERT, id, cost);
            end else begin
                if (wide_ids.size() > 0 && $urandom_range(99) < 30)
                    id = wide_ids.pop_front();
                else if ($urandom_range(99) < 5)
                    id = 16'($urandom);
                else
                    id = 16'($urandom_range(15));
                send_req(REQ_REMOVE, id, cost);
            end
        end
    endtask

    task automatic run_phase(input int snd_pct, input int rcv_pct);
        send_idle_pct = snd_pct;
        recv_idle_pct = rcv_pct;
        repeat (3) begin
            run_burst(90, 90);
            run_burst(110, 12);
        end
    endtask

    initial begin
        int settle;
        rst_n    = 1'b0;
        s_tvalid = 1'b0;
        s_tuser  = REQ_INSERT;
        s_tdata  = '0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed
        send_req(REQ_REMOVE, 16'h0005, 24'h000000);   // empty list
        send_req(REQ_INSERT, 16'h0000, 24'h000000);
        send_req(REQ_INSERT, 16'hFFFF, 24'hFFFFFF);
        send_req(REQ_INSERT, 16'h1234, 24'h000100);
        send_req(REQ_INSERT, 16'h0042, 24'h000100);   // tie goes ahead
        send_req(REQ_INSERT, 16'h0042, 24'h800000);   // duplicate id
        send_req(REQ_INSERT, 16'hAAAA, 24'h000000);   // tie with head
        send_req(REQ_REMOVE, 16'h0042, 24'hFFFFFF);   // nearest the head
        send_req(REQ_REMOVE, 16'h0042, 24'h000000);
        send_req(REQ_REMOVE, 16'h0042, 24'h000000);   // not found
        send_req(REQ_REMOVE, 16'hBEEF, 24'h123456);
        send_req(REQ_REMOVE, 16'hAAAA, 24'h000000);   // head
        send_req(REQ_REMOVE, 16'hFFFF, 24'h000000);   // tail
        send_req(REQ_REMOVE, 16'h0000, 24'h000000);
        send_req(REQ_REMOVE, 16'h1234, 24'h000000);   // last entry
        send_req(REQ_REMOVE, 16'h0000, 24'h000000);   // empty again
        send_req(REQ_INSERT, 16'h5555, 24'h555555);
        send_req(REQ_INSERT, 16'hAAAA, 24'hAAAAAA);
        send_req(REQ_REMOVE, 16'hAAAA, 24'h555555);
        send_req(REQ_REMOVE, 16'h5555, 24'hAAAAAA);

        run_phase(32, 78);
        run_phase(78, 32);
        run_phase(0, 0);

        s_tvalid <= 1'b0;
        settle = 0;
        while (pending != 0 && settle < 20000) begin
            @(negedge clk);
            settle++;
        end
        repeat (4) @(negedge clk);
        if (fail_count == 0 && pending == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
